/* hw/rtl/stopwatch_adc_display_controller_top_defines.svh */
// Assertion macros used by the top-level RTL file.
`ifndef STOPWATCH_ADC_DISPLAY_CONTROLLER_TOP_DEFINES_SVH
`define STOPWATCH_ADC_DISPLAY_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWADC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swadc assertion failed");

// Next-cycle implication, checked outside reset.
`define SWADC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swadc assertion failed");

`endif

/* hw/rtl/swadc_pkg.sv */
`default_nettype none

package swadc_pkg;

    // One tick transaction.
    typedef struct packed {
        logic        show_button;
        logic        reset_button;
        logic        adc_valid;
        logic [11:0] adc_value;
    } t_in_item;

    // One display transaction.
    typedef struct packed {
        logic [3:0] digit_0;
        logic [3:0] digit_1;
        logic [3:0] digit_2;
        logic [3:0] digit_3;
        logic [3:0] point_mask;
        logic       at_limit;
        logic [1:0] view;
    } t_out_item;

    // Tick after the input register: sample already split by 100.
    typedef struct packed {
        logic       show_button;
        logic       reset_button;
        logic       adc_valid;
        logic [5:0] adc_hund;   // sample / 100
        logic [6:0] adc_rem;    // sample % 100
    } t_prep_item;

    // Debouncer control.
    typedef struct packed {
        logic       step;
        logic       level;
        logic [7:0] settle;
    } t_db_ctrl;

    localparam logic [1:0] CFG_TENTH_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_TIME = 2'd1;
    localparam logic [1:0] CFG_SCAN_PERIOD   = 2'd2;
    localparam logic [1:0] CFG_TOGGLE_PERIOD = 2'd3;

    localparam logic [1:0] VIEW_HIDDEN    = 2'd0;
    localparam logic [1:0] VIEW_STOPWATCH = 2'd1;
    localparam logic [1:0] VIEW_ADC       = 2'd2;

    localparam logic [3:0] PTS_RESET = 4'b1111;
    localparam logic [3:0] PTS_TIME  = 4'b1010;
    localparam logic [3:0] PTS_ADC   = 4'b1000;

    localparam logic [15:0] RST_TENTH_PERIOD  = 16'd100;
    localparam logic [7:0]  RST_DEBOUNCE_TIME = 8'd30;
    localparam logic [7:0]  RST_SCAN_PERIOD   = 8'd5;
    localparam logic [15:0] RST_TOGGLE_PERIOD = 16'd4000;

    localparam logic [15:0] TIME_LIMIT = 16'h9599;   // 9.59.9 as BCD
    localparam logic [15:0] TIME_HIDDEN = 16'h8888;

    // Tens and units of a value below 100: reciprocal of 10 is 205 / 2048.
    function automatic logic [7:0] split_tens(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - (7'(tens) * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/swadc_in_stage.sv */
`default_nettype none

module swadc_in_stage (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire swadc_pkg::t_in_item   i_item,
    input  wire logic                  i_take,
    output logic                       o_valid,
    output swadc_pkg::t_prep_item      o_prep
);
    import swadc_pkg::*;

    logic        r_valid;
    t_prep_item  r_prep;
    t_prep_item  n_prep;
    logic [24:0] w_prod;
    logic [5:0]  w_hund;

    // Split the sample by 100: reciprocal 5243 / 2^19 is exact below 4096.
    assign w_prod = 25'(i_item.adc_value) * 25'd5243;
    assign w_hund = w_prod[24:19];

    always_comb begin
        n_prep.show_button  = i_item.show_button;
        n_prep.reset_button = i_item.reset_button;
        n_prep.adc_valid    = i_item.adc_valid;
        n_prep.adc_hund     = w_hund;
        n_prep.adc_rem      = 7'(i_item.adc_value - (12'(w_hund) * 12'd100));
    end

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_prep  = r_prep;

    // Hold the transaction until the core takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prep <= n_prep;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/swadc_debounce.sv */
`default_nettype none

module swadc_debounce (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire swadc_pkg::t_db_ctrl i_ctrl,
    output logic                     o_press
);
    import swadc_pkg::*;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_FALL   = 2'd1;
    localparam logic [1:0] ST_LOW    = 2'd2;
    localparam logic [1:0] ST_RISING = 2'd3;

    logic [1:0] r_state, n_state;
    logic [7:0] r_timer, n_timer;

    // Walk the four debounce states, one step per tick.
    always_comb begin
        n_state = r_state;
        n_timer = r_timer;
        o_press = 1'b0;
        case (r_state)
            ST_NORMAL: begin
                if (!i_ctrl.level) begin
                    n_timer = '0;
                    n_state = ST_FALL;
                    o_press = i_ctrl.step;
                end
            end
            ST_FALL: begin
                if (r_timer >= i_ctrl.settle) n_state = ST_LOW;
                else n_timer = r_timer + 8'd1;
            end
            ST_LOW: begin
                if (i_ctrl.level) begin
                    n_timer = '0;
                    n_state = ST_RISING;
                end
            end
            ST_RISING: begin
                if (r_timer >= i_ctrl.settle) n_state = ST_NORMAL;
                else n_timer = r_timer + 8'd1;
            end
            default: begin
                n_state = ST_NORMAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NORMAL;
            r_timer <= '0;
        end else if (i_ctrl.step) begin
            r_state <= n_state;
            r_timer <= n_timer;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/swadc_out_buf.sv */
`default_nettype none

module swadc_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire swadc_pkg::t_out_item  i_item,
    output logic                       o_space,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output swadc_pkg::t_out_item       o_item
);
    import swadc_pkg::*;

    logic [1:0] r_count;
    t_out_item  r_head;
    t_out_item  r_second;
    logic       w_pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_head;
    assign w_pop   = o_valid && i_ready;

    // Track occupancy of the two slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push && !w_pop) begin
            r_count <= r_count + 2'd1;
        end else if (w_pop && !i_push) begin
            r_count <= r_count - 2'd1;
        end
    end

    // Load the head and skid slots.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (i_push && r_count == 2'd1) r_head <= i_item;
            else r_head <= r_second;
            if (i_push && r_count == 2'd2) r_second <= i_item;
        end else if (i_push) begin
            if (r_count == 2'd0) r_head <= i_item;
            else r_second <= i_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/stopwatch_adc_display_controller_top.sv */
// Channel   | Handshake            | Payload
// tick in   | i_valid / o_ready    | i_item  (swadc_pkg::t_in_item)
// display   | o_valid / i_ready    | o_item  (swadc_pkg::t_out_item)
// config    | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One tick transaction per cycle while not stalled; a display transaction leaves through
// the input register, then the state update into a two-slot output buffer.
// Throughput is set by the output buffer: ticks stall only while both slots are full.
// i_rst_n is synchronous, active low; it restores state, timer and config registers to defaults.
// Ticks that cause no display still pass through the input register.
`default_nettype none

`include "stopwatch_adc_display_controller_top_defines.svh"

module stopwatch_adc_display_controller_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire swadc_pkg::t_in_item   i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output swadc_pkg::t_out_item       o_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data
);
    import swadc_pkg::*;

    // Configuration
    logic [15:0] r_tenth_period;
    logic [7:0]  r_debounce_time;
    logic [7:0]  r_scan_period;
    logic [15:0] r_toggle_period;

    // Stopwatch and view state
    logic [15:0] r_tick, n_tick;
    logic [15:0] r_time, n_time;
    logic        r_limit, n_limit;
    logic        r_show_en, n_show_en;
    logic        r_adc_view, n_adc_view;
    logic [3:0]  r_points, n_points;
    logic [15:0] r_toggle, n_toggle;
    logic [7:0]  r_scan, n_scan;
    logic [15:0] r_adc_bcd, n_adc_bcd;

    logic        w_in_valid;
    t_prep_item  w_prep;
    logic        w_space;
    logic        w_fire;
    logic        w_emit;
    t_out_item   w_out;
    t_db_ctrl    w_show_ctrl;
    t_db_ctrl    w_reset_ctrl;
    logic        w_show_press;
    logic        w_reset_press;
    logic [7:0]  w_hund_bcd;
    logic [7:0]  w_rem_bcd;

    assign w_fire = w_in_valid && w_space;

    swadc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_prep  (w_prep)
    );

    assign w_show_ctrl  = '{step: w_fire, level: w_prep.show_button,
                            settle: r_debounce_time};
    assign w_reset_ctrl = '{step: w_fire, level: w_prep.reset_button,
                            settle: r_debounce_time};

    swadc_debounce u_db_show (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_show_ctrl),
        .o_press (w_show_press)
    );

    swadc_debounce u_db_reset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_reset_ctrl),
        .o_press (w_reset_press)
    );

    // Finish the decimal split of the sample (it never exceeds 4095, so no clamp).
    assign w_hund_bcd = split_tens(7'(w_prep.adc_hund));
    assign w_rem_bcd  = split_tens(w_prep.adc_rem);

    // Advance all state for one tick and build the display word.
    always_comb begin
        n_time     = r_time;
        n_limit    = r_limit;
        n_show_en  = r_show_en;
        n_adc_view = r_adc_view;
        n_points   = r_points;
        n_adc_bcd  = r_adc_bcd;
        w_emit     = 1'b0;

        // stopwatch period
        n_tick = r_tick + 16'd1;
        if (n_tick >= r_tenth_period) begin
            n_tick  = '0;
            n_limit = 1'b0;
            if (r_time[3:0] < 4'd9) begin
                n_time[3:0] = r_time[3:0] + 4'd1;
            end else begin
                n_time[3:0] = 4'd0;
                if (r_time[7:4] < 4'd9) begin
                    n_time[7:4] = r_time[7:4] + 4'd1;
                end else begin
                    n_time[7:4] = 4'd0;
                    if (r_time[11:8] < 4'd5) begin
                        n_time[11:8] = r_time[11:8] + 4'd1;
                    end else begin
                        n_time[11:8] = 4'd0;
                        if (r_time[15:12] < 4'd9) begin
                            n_time[15:12] = r_time[15:12] + 4'd1;
                        end else begin
                            n_time  = TIME_LIMIT;
                            n_limit = 1'b1;
                        end
                    end
                end
            end
        end

        n_toggle = (r_toggle != 16'hFFFF) ? r_toggle + 16'd1 : r_toggle;
        n_scan   = (r_scan != 8'hFF) ? r_scan + 8'd1 : r_scan;

        if (w_prep.adc_valid) n_adc_bcd = {w_hund_bcd, w_rem_bcd};

        if (w_show_press) n_show_en = 1'b1;

        if (w_reset_press) begin
            n_time     = '0;
            n_limit    = 1'b0;
            n_show_en  = 1'b0;
            n_adc_view = 1'b0;
            n_toggle   = '0;
        end

        // view swap
        if (n_show_en) begin
            if (n_toggle >= r_toggle_period) begin
                n_toggle   = '0;
                n_adc_view = !n_adc_view;
            end
        end else begin
            n_adc_view = 1'b0;
        end

        // scan
        w_out = '0;
        if (n_scan >= r_scan_period) begin
            n_scan = '0;
            w_emit = 1'b1;
            if (!n_show_en) begin
                {w_out.digit_3, w_out.digit_2, w_out.digit_1, w_out.digit_0} = TIME_HIDDEN;
                w_out.view = VIEW_HIDDEN;
            end else if (!n_adc_view) begin
                {w_out.digit_3, w_out.digit_2, w_out.digit_1, w_out.digit_0} = n_time;
                n_points   = PTS_TIME;
                w_out.view = VIEW_STOPWATCH;
            end else begin
                {w_out.digit_3, w_out.digit_2, w_out.digit_1, w_out.digit_0} = n_adc_bcd;
                n_points   = PTS_ADC;
                w_out.view = VIEW_ADC;
            end
            w_out.point_mask = n_points;
            w_out.at_limit   = n_limit;
        end
    end

    swadc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire && w_emit),
        .i_item  (w_out),
        .o_space (w_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // Take configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenth_period  <= RST_TENTH_PERIOD;
            r_debounce_time <= RST_DEBOUNCE_TIME;
            r_scan_period   <= RST_SCAN_PERIOD;
            r_toggle_period <= RST_TOGGLE_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TENTH_PERIOD:  r_tenth_period  <= i_cfg_data;
                CFG_DEBOUNCE_TIME: r_debounce_time <= i_cfg_data[7:0];
                CFG_SCAN_PERIOD:   r_scan_period   <= i_cfg_data[7:0];
                CFG_TOGGLE_PERIOD: r_toggle_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Commit the tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_time     <= '0;
            r_limit    <= 1'b0;
            r_show_en  <= 1'b0;
            r_adc_view <= 1'b0;
            r_points   <= PTS_RESET;
            r_toggle   <= '0;
            r_scan     <= '0;
            r_adc_bcd  <= '0;
        end else if (w_fire) begin
            r_tick     <= n_tick;
            r_time     <= n_time;
            r_limit    <= n_limit;
            r_show_en  <= n_show_en;
            r_adc_view <= n_adc_view;
            r_points   <= n_points;
            r_toggle   <= n_toggle;
            r_scan     <= n_scan;
            r_adc_bcd  <= n_adc_bcd;
        end
    end

    `SWADC_ASSERT_IMPL(a_limit_digits, r_limit, r_time == TIME_LIMIT)
    `SWADC_ASSERT_IMPL(a_adc_needs_show, r_adc_view, r_show_en)
    `SWADC_ASSERT_IMPL(a_hidden_eights, o_valid && o_item.view == VIEW_HIDDEN,
        o_item.digit_0 == 4'd8 && o_item.digit_3 == 4'd8)
    `SWADC_ASSERT_IMPL(a_time_points, o_valid && o_item.view == VIEW_STOPWATCH,
        o_item.point_mask == PTS_TIME)
    `SWADC_ASSERT_NEXT(a_reset_press_hides, w_fire && w_reset_press, !r_show_en && !r_limit)

endmodule

`default_nettype wire
